// ===== design/mudec_pkg.sv =====
package mudec_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DRAIN  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam logic [3:0] HdrMaskHi = 4'd4;
  localparam logic [3:0] HdrMaskLo = 4'd5;
  localparam logic [3:0] HdrLast   = 4'd12;
  localparam logic [7:0] CharBias  = 8'h20;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } result_t;

  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h44;
      2'd1:    ch = 8'h5A;
      2'd2:    ch = 8'h59;
      default: ch = 8'h41;
    endcase
    return ch;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CharBias;
    return diff[5:0];
  endfunction

endpackage

// ===== design/masked_uudecode_record_decoder_unit.sv =====
// Masked uudecode record decoder.
// Input channel: one record character per request on char_in_i, with
// end_of_record_i marking the last character of a record; accepted when
// in_valid_i is high and in_stall_o is low.
// Output channel: byte_out_o and out_kind_o (data, finished, error), taken
// when out_valid_o is high and out_stall_i is low. A request yields zero or
// one result; byte_out_o is zero for finished and error results.
// A result is registered in the output register, or in the skid register while the receiver stalls.
// Throughput: one character per cycle while in_stall_o is low. The decode state is updated in the
// cycle of acceptance, so requests follow back to back.
// When the receiver stalls, the output register holds its result and one
// more result goes to a skid register; in_stall_o rises only while the
// skid register is full, and then drops as soon as the output moves on.
// Reset clears the decode state to the header phase with a zero mask and
// empties both result registers.
module masked_uudecode_record_decoder_unit
  import mudec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_record_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [1:0] out_kind_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] header_index_q, header_index_d;
  logic [1:0] group_position_q, group_position_d;
  logic [5:0] bytes_left_q, bytes_left_d;
  logic [5:0] prior_sextet_q, prior_sextet_d;
  logic [7:0] mask_byte_q, mask_byte_d;

  logic       out_valid_q, skid_valid_q;
  result_t    out_q, skid_q;

  logic       accept;
  logic       res_valid;
  result_t    res;
  logic [5:0] s;
  logic [7:0] value;
  logic       have_byte;
  logic       clear;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = skid_valid_q;
  assign s          = sextet_of(char_in_i);

  always_comb begin
    case (group_position_q)
      2'd1:    value = {prior_sextet_q, s[5:4]};
      2'd2:    value = {prior_sextet_q[3:0], s[5:2]};
      2'd3:    value = {prior_sextet_q[1:0], s};
      default: value = 8'd0;
    endcase
  end

  always_comb begin
    phase_d          = phase_q;
    header_index_d   = header_index_q;
    group_position_d = group_position_q;
    bytes_left_d     = bytes_left_q;
    prior_sextet_d   = prior_sextet_q;
    mask_byte_d      = mask_byte_q;
    res_valid        = 1'b0;
    res.data         = 8'd0;
    res.kind         = KIND_DATA;
    have_byte        = 1'b0;
    clear            = 1'b0;

    case (phase_q)
      PH_DRAIN: begin
        clear = end_of_record_i;
      end
      PH_HEADER: begin
        if (!header_index_q[3] && !header_index_q[2] &&
            char_in_i != magic_char(header_index_q[1:0])) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          clear     = end_of_record_i;
          phase_d   = PH_DRAIN;
        end else begin
          if (header_index_q == HdrMaskHi) begin
            mask_byte_d = {s, 2'b00};
          end else if (header_index_q == HdrMaskLo) begin
            mask_byte_d = mask_byte_q | {6'd0, s[5:4]};
          end
          if (header_index_q >= HdrLast) begin
            header_index_d = 4'd0;
            phase_d        = PH_COUNT;
          end else begin
            header_index_d = header_index_q + 4'd1;
          end
          if (end_of_record_i) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            clear     = 1'b1;
          end
        end
      end
      PH_COUNT: begin
        if (s == 6'd0) begin
          res_valid = 1'b1;
          res.kind  = KIND_DONE;
          clear     = end_of_record_i;
          phase_d   = PH_DRAIN;
        end else begin
          bytes_left_d     = s;
          group_position_d = 2'd0;
          phase_d          = PH_DATA;
          if (end_of_record_i) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            clear     = 1'b1;
          end
        end
      end
      default: begin
        if (group_position_q != 2'd0 && bytes_left_q != 6'd0) begin
          have_byte    = 1'b1;
          bytes_left_d = bytes_left_q - 6'd1;
        end
        prior_sextet_d = s;
        if (group_position_q == 2'd3) begin
          group_position_d = 2'd0;
          if (bytes_left_d == 6'd0) begin
            phase_d = PH_COUNT;
          end
        end else begin
          group_position_d = group_position_q + 2'd1;
        end
        if (end_of_record_i) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          clear     = 1'b1;
        end else if (have_byte) begin
          res_valid = 1'b1;
          res.data  = value ^ mask_byte_q;
          res.kind  = KIND_DATA;
        end
      end
    endcase

    if (clear) begin
      phase_d          = PH_HEADER;
      header_index_d   = 4'd0;
      group_position_d = 2'd0;
      bytes_left_d     = 6'd0;
      prior_sextet_d   = 6'd0;
      mask_byte_d      = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HEADER;
      header_index_q   <= 4'd0;
      group_position_q <= 2'd0;
      bytes_left_q     <= 6'd0;
      prior_sextet_q   <= 6'd0;
      mask_byte_q      <= 8'd0;
    end else if (accept) begin
      phase_q          <= phase_d;
      header_index_q   <= header_index_d;
      group_position_q <= group_position_d;
      bytes_left_q     <= bytes_left_d;
      prior_sextet_q   <= prior_sextet_d;
      mask_byte_q      <= mask_byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_q.data;
  assign out_kind_o  = out_q.kind;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KIND_DATA |-> out_q.data == 8'd0)
    else $error("non-data result carries a nonzero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> bytes_left_q != 6'd0 || group_position_q != 2'd0)
    else $error("line has no bytes left at the start of a group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> header_index_q <= HdrLast)
    else $error("header index ran past the header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COUNT || phase_q == PH_DATA) |-> header_index_q == 4'd0)
    else $error("header index not cleared after the header");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mudec_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 400;
  localparam int HoldAfter = 300;
  localparam int ItemTarget = 1600;
  localparam logic [31:0] MagicWord = "DZYA";

  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
  } char_req_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_TOGGLE,
    STALL_HEAVY
  } stall_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_in_i = 8'h00;
  logic       end_of_record_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] byte_out_o;
  logic [1:0] out_kind_o;

  masked_uudecode_record_decoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_record_i(end_of_record_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_out_o     (byte_out_o),
    .out_kind_o     (out_kind_o)
  );

  char_req_t   pending_q[$];
  result_t     decoded_q[$];
  char_req_t   req;
  result_t     want;
  int          err_count = 0;
  int          in_count = 0;
  int          total_items = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  logic        held = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;

  // decoder state mirror
  phase_e     ph;
  logic [3:0] hdr_idx;
  logic [1:0] grp_pos;
  logic [5:0] left_cnt;
  logic [5:0] prev_sx;
  logic [7:0] mask;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got_v, exp_v);
    err_count++;
  endtask

  task automatic clear_state();
    ph = PH_HEADER;
    hdr_idx = '0;
    grp_pos = '0;
    left_cnt = '0;
    prev_sx = '0;
    mask = '0;
  endtask

  task automatic push_result(input logic [7:0] data, input kind_e kind);
    result_t r;
    r.data = data;
    r.kind = kind;
    decoded_q.push_back(r);
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eor);
    logic [5:0] sx;
    logic [7:0] val;
    logic       emit;
    sx = sextet_of(c);
    val = '0;
    emit = 1'b0;
    case (ph)
      PH_DRAIN: begin
        if (eor) clear_state();
        return;
      end
      PH_HEADER: begin
        if (hdr_idx < 4 && c != MagicWord[8*(3-hdr_idx[1:0]) +: 8]) begin
          if (eor) clear_state();
          else ph = PH_DRAIN;
          push_result(8'h00, KIND_ERROR);
          return;
        end
        if (hdr_idx == HdrMaskHi) mask = {sx, 2'b00};
        else if (hdr_idx == HdrMaskLo) mask = mask | {6'b0, sx[5:4]};
        if (hdr_idx >= HdrLast) begin
          hdr_idx = '0;
          ph = PH_COUNT;
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      PH_COUNT: begin
        if (sx == 6'd0) begin
          if (eor) clear_state();
          else ph = PH_DRAIN;
          push_result(8'h00, KIND_DONE);
          return;
        end
        left_cnt = sx;
        grp_pos = '0;
        ph = PH_DATA;
      end
      default: begin
        case (grp_pos)
          2'd1: val = {prev_sx, sx[5:4]};
          2'd2: val = {prev_sx[3:0], sx[5:2]};
          2'd3: val = {prev_sx[1:0], sx};
          default: val = '0;
        endcase
        if (grp_pos != 2'd0 && left_cnt != 6'd0) begin
          emit = 1'b1;
          left_cnt = left_cnt - 1'b1;
        end
        prev_sx = sx;
        if (grp_pos == 2'd3) begin
          grp_pos = '0;
          if (left_cnt == 6'd0) ph = PH_COUNT;
        end else begin
          grp_pos = grp_pos + 1'b1;
        end
      end
    endcase
    if (eor) begin
      clear_state();
      push_result(8'h00, KIND_ERROR);
    end else if (emit) begin
      push_result(val ^ mask, KIND_DATA);
    end
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] encode_sextet(input logic [5:0] s);
    logic [1:0] alias_sel;
    alias_sel = 2'($urandom_range(0, 3));
    return 8'h20 + {2'b00, s} + {alias_sel, 6'b0};
  endfunction

  task automatic push_item(input logic [7:0] c, input logic eor);
    char_req_t r;
    r.ch = c;
    r.eor = eor;
    pending_q.push_back(r);
  endtask

  task automatic add_record();
    logic [7:0] body[$];
    int         style;
    int         nlines;
    int         cnt;
    int         pick;
    int         term_at;
    int         bad_at;
    int         stop_at;
    style = $urandom_range(0, 99);
    if (style < 8) begin
      cnt = $urandom_range(1, 20);
      repeat (cnt) body.push_back(rand_char());
      stop_at = body.size() - 1;
    end else begin
      for (int i = 0; i < 4; i++) body.push_back(MagicWord[8*(3-i) +: 8]);
      repeat (9) body.push_back(rand_char());
      nlines = $urandom_range(0, 4);
      repeat (nlines) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) cnt = $urandom_range(1, 12);
        else if (pick < 19) cnt = $urandom_range(13, 45);
        else cnt = $urandom_range(46, 63);
        body.push_back(encode_sextet(cnt[5:0]));
        repeat (4 * ((cnt + 2) / 3)) body.push_back(rand_char());
      end
      term_at = body.size();
      body.push_back(encode_sextet(6'd0));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) body.push_back(rand_char());
      stop_at = body.size() - 1;
      if (style < 18) begin
        stop_at = $urandom_range(0, term_at - 1);
      end else if (style < 28) begin
        bad_at = $urandom_range(0, 3);
        body[bad_at] = body[bad_at] ^ (8'd1 << $urandom_range(0, 7));
        stop_at = $urandom_range(bad_at, body.size() - 1);
      end
    end
    for (int i = 0; i <= stop_at; i++) push_item(body[i], i == stop_at);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_in_i <= 8'h00;
      end_of_record_i <= 1'b0;
      clear_state();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_char(char_in_i, end_of_record_i);
        in_count <= in_count + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req = pending_q.pop_front();
          in_valid_i <= 1'b1;
          char_in_i <= req.ch;
          end_of_record_i <= req.eor;
          if (burst_left == 0) burst_left = $urandom_range(1, 48);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!held && in_count >= HoldAfter) begin
      held <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 128);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_TOGGLE: out_stall_i <= !out_stall_i;
        default:      out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result without request, kind", out_kind_o, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_kind_o !== want.kind) report_mismatch("out_kind", out_kind_o, want.kind);
        if (byte_out_o !== want.data) report_mismatch("byte_out", byte_out_o, want.data);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [8*20-1:0] first_rec;
    // mask 8'hFD, short group, finished without end, then drain
    first_rec = {"DZYA", 8'h5F, 8'hFF, 8'h00, 8'hFF, "12345",
                 8'h22, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h60, 8'hAA};
    for (int i = 0; i < 20; i++) push_item(first_rec[8*(19-i) +: 8], i == 19);
    push_item("D", 1'b0);
    push_item("Z", 1'b0);
    push_item("X", 1'b1);
    push_item("D", 1'b1);
    while (pending_q.size() < ItemTarget) add_record();
    total_items = pending_q.size();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (in_count != total_items || decoded_q.size() != 0);
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) report_mismatch("results never delivered", decoded_q.size(), 0);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mudec_pkg.sv
design/masked_uudecode_record_decoder_unit.sv
test/tb.sv
